[hw/rtl/faa_pkg.sv]
// Shared types, constants and codes of the frame accumulate/average block.
package faa_pkg;

  // Default sizes of the sum store
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int SUM_BITS_DEF   = 32;

  // Field widths of the channels
  localparam int MODE_W  = 2;
  localparam int COORD_W = 12;
  localparam int PIX_W   = 8;
  localparam int OUT_W   = 16;
  localparam int FC_W    = 16;
  localparam int WIN_W   = 9;

  // Configuration port
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int RIDX_W  = 3;

  localparam logic [RIDX_W-1:0] REG_WINDOW_WIDTH  = 3'd0;
  localparam logic [RIDX_W-1:0] REG_WINDOW_HEIGHT = 3'd1;
  localparam logic [RIDX_W-1:0] REG_ROW_OFFSET    = 3'd2;
  localparam logic [RIDX_W-1:0] REG_FRAME_COUNT   = 3'd3;
  localparam logic [RIDX_W-1:0] REG_DEPTH_MODE    = 3'd4;

  // Register reset values
  localparam logic [WIN_W-1:0]   RST_WINDOW_WIDTH  = 9'd256;
  localparam logic [WIN_W-1:0]   RST_WINDOW_HEIGHT = 9'd256;
  localparam logic [COORD_W-1:0] RST_ROW_OFFSET    = 12'd0;
  localparam logic [FC_W-1:0]    RST_FRAME_COUNT   = 16'd1;

  // Output saturation limits
  localparam logic [OUT_W-1:0] BYTE_MAX = 16'd255;
  localparam logic [OUT_W-1:0] WORD_MAX = 16'hFFFF;

  // Operation codes of the mode field
  typedef enum logic [MODE_W-1:0] {
    MODE_ACC   = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2
  } faa_mode_t;

  typedef struct packed {
    logic [WIN_W-1:0]   window_width;
    logic [WIN_W-1:0]   window_height;
    logic [COORD_W-1:0] row_offset;
    logic [FC_W-1:0]    frame_count;
    logic               depth_mode;
  } faa_cfg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_ACC_WR,
    ST_RD_DATA,
    ST_DIV,
    ST_EMIT
  } faa_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic rd_en;
    logic acc_wr;
    logic clr_start;
    logic clr_step;
    logic div_start;
    logic div_wb;
    logic res_zero;
    logic res_mem16;
    logic emit;
  } faa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              acc_win;
    logic              rd_win;
    logic              depth16;
    logic              div_done;
    logic              clr_last;
    logic              out_free;
  } faa_stat_t;

endpackage

[hw/rtl/faa_channels.sv]
// Stream interfaces for the input transaction and the result transaction.
interface faa_in_if import faa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [COORD_W-1:0] src_row;
  logic [COORD_W-1:0] src_col;
  logic [PIX_W-1:0]   pixel_in;

  modport source (output valid, mode, src_row, src_col, pixel_in, input ready);
  modport sink (input valid, mode, src_row, src_col, pixel_in, output ready);
endinterface

interface faa_out_if import faa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] pixel_out;

  modport source (output valid, pixel_out, input ready);
  modport sink (input valid, pixel_out, output ready);
endinterface

[hw/rtl/faa_cfg.sv]
// APB-style configuration register file.
module faa_cfg import faa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output faa_cfg_t           cfg
);

  logic [RIDX_W-1:0] ridx;
  logic              wr_en;

  assign pready = 1'b1;
  assign ridx   = paddr[PADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_width  <= RST_WINDOW_WIDTH;
      cfg.window_height <= RST_WINDOW_HEIGHT;
      cfg.row_offset    <= RST_ROW_OFFSET;
      cfg.frame_count   <= RST_FRAME_COUNT;
      cfg.depth_mode    <= 1'b0;
    end else if (wr_en) begin
      case (ridx)
        REG_WINDOW_WIDTH:  cfg.window_width  <= pwdata[WIN_W-1:0];
        REG_WINDOW_HEIGHT: cfg.window_height <= pwdata[WIN_W-1:0];
        REG_ROW_OFFSET:    cfg.row_offset    <= pwdata[COORD_W-1:0];
        REG_FRAME_COUNT:   cfg.frame_count   <= pwdata[FC_W-1:0];
        REG_DEPTH_MODE:    cfg.depth_mode    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (ridx)
      REG_WINDOW_WIDTH:  prdata = PDATA_W'(cfg.window_width);
      REG_WINDOW_HEIGHT: prdata = PDATA_W'(cfg.window_height);
      REG_ROW_OFFSET:    prdata = PDATA_W'(cfg.row_offset);
      REG_FRAME_COUNT:   prdata = PDATA_W'(cfg.frame_count);
      REG_DEPTH_MODE:    prdata = PDATA_W'(cfg.depth_mode);
      default:           prdata = '0;
    endcase
  end

endmodule

[hw/rtl/faa_div.sv]
// Restoring divider: one quotient bit per cycle, sum by frame count.
module faa_div import faa_pkg::*; #(
  parameter int SUM_BITS = SUM_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [SUM_BITS-1:0] dividend,
  input  logic [FC_W-1:0]     divisor,
  output logic                done,
  output logic [SUM_BITS-1:0] quotient
);

  localparam int CNT_W = $clog2(SUM_BITS + 1);

  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [FC_W-1:0]  rem;
  logic [FC_W-1:0]  dvs;
  logic [FC_W:0]    shifted;
  logic             fits;

  assign shifted = {rem, quotient[SUM_BITS-1]};
  assign fits    = shifted >= {1'b0, dvs};

  // Control: iteration count and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(SUM_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift-subtract step
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[SUM_BITS-2:0], fits};
      rem      <= fits ? FC_W'(shifted - {1'b0, dvs}) : shifted[FC_W-1:0];
    end
  end

endmodule

[hw/rtl/faa_ctrl.sv]
// Controller state machine: sequences accumulate, readout and clear.
module faa_ctrl import faa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  faa_stat_t stat,
  output faa_cmd_t  cmd
);

  faa_state_t state, state_next;

  // State register; reset starts the clearing sweep
  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat.mode)
          MODE_ACC: begin
            if (stat.acc_win) begin
              cmd.rd_en  = 1'b1;
              state_next = ST_ACC_WR;
            end else begin
              state_next = ST_IDLE;
            end
          end
          MODE_READ: begin
            if (stat.rd_win) begin
              cmd.rd_en  = 1'b1;
              state_next = ST_RD_DATA;
            end else begin
              cmd.res_zero = 1'b1;
              state_next   = ST_EMIT;
            end
          end
          MODE_CLEAR: begin
            cmd.clr_start = 1'b1;
            state_next    = ST_CLEAR;
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_ACC_WR: begin
        cmd.acc_wr = 1'b1;
        state_next = ST_IDLE;
      end
      ST_RD_DATA: begin
        if (stat.depth16) begin
          cmd.res_mem16 = 1'b1;
          state_next    = ST_EMIT;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (stat.div_done) begin
          cmd.div_wb = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[hw/rtl/faa_datapath.sv]
// Datapath: input capture, window check, sum store, divider, output register.
module faa_datapath import faa_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int SUM_BITS   = SUM_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  faa_cfg_t           cfg,
  input  faa_cmd_t           cmd,
  output faa_stat_t          stat,
  input  logic [MODE_W-1:0]  in_mode,
  input  logic [COORD_W-1:0] in_row,
  input  logic [COORD_W-1:0] in_col,
  input  logic [PIX_W-1:0]   in_pix,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [OUT_W-1:0]   out_pixel
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [COORD_W:0] MAXW_C = (COORD_W + 1)'(MAX_WIDTH);
  localparam logic [COORD_W:0] MAXH_C = (COORD_W + 1)'(MAX_HEIGHT);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  logic [MODE_W-1:0]  mode_r;
  logic [COORD_W-1:0] row_r;
  logic [COORD_W-1:0] col_r;
  logic [PIX_W-1:0]   pix_r;

  logic [COORD_W-1:0] win_row;
  logic [COORD_W-1:0] row_sel;
  logic               col_ok;
  logic [ADDR_W-1:0]  addr;
  logic [ADDR_W-1:0]  addr_r;
  logic [ADDR_W-1:0]  clr_addr;

  logic [SUM_BITS-1:0] mem [DEPTH];
  logic [SUM_BITS-1:0] mem_q;
  logic                we;
  logic [ADDR_W-1:0]   wa;
  logic [SUM_BITS-1:0] wd;

  logic [SUM_BITS:0]   acc_raw;
  logic [SUM_BITS-1:0] acc_sum;
  logic [FC_W-1:0]     divisor;
  logic                div_done;
  logic [SUM_BITS-1:0] quo;
  logic [OUT_W-1:0]    res;

  // Input capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r <= in_mode;
      row_r  <= in_row;
      col_r  <= in_col;
      pix_r  <= in_pix;
    end
  end

  // Window checks and store address
  assign win_row = row_r - cfg.row_offset;
  assign col_ok  = ({1'b0, col_r} < {4'd0, cfg.window_width}) && ({1'b0, col_r} < MAXW_C);
  assign stat.acc_win = (row_r >= cfg.row_offset) && col_ok &&
                        ({1'b0, win_row} < {4'd0, cfg.window_height}) &&
                        ({1'b0, win_row} < MAXH_C);
  assign stat.rd_win  = col_ok && ({1'b0, row_r} < {4'd0, cfg.window_height}) &&
                        ({1'b0, row_r} < MAXH_C);
  assign row_sel = (mode_r == MODE_ACC) ? win_row : row_r;
  assign addr    = ADDR_W'(32'(row_sel) * 32'(MAX_WIDTH) + 32'(col_r));

  always_ff @(posedge clk) begin
    if (cmd.rd_en) addr_r <= addr;
  end

  // Clearing sweep counter
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_start) clr_addr <= '0;
    else if (cmd.clr_step)    clr_addr <= clr_addr + 1'b1;
  end

  // Saturating accumulate
  assign acc_raw = {1'b0, mem_q} + (SUM_BITS + 1)'(pix_r);
  assign acc_sum = acc_raw[SUM_BITS] ? '1 : acc_raw[SUM_BITS-1:0];

  // Store write port select
  always_comb begin
    we = 1'b0;
    wa = addr_r;
    wd = acc_sum;
    if (cmd.clr_step) begin
      we = 1'b1;
      wa = clr_addr;
      wd = '0;
    end else if (cmd.acc_wr) begin
      we = 1'b1;
    end else if (cmd.div_wb) begin
      we = 1'b1;
      wd = quo;
    end
  end

  // Sum store, registered read
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (cmd.rd_en) mem_q <= mem[addr];
  end

  // Averaging divider; a zero frame count divides by one
  assign divisor = (cfg.frame_count == '0) ? FC_W'(1) : cfg.frame_count;

  faa_div #(.SUM_BITS(SUM_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (mem_q),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quo)
  );

  // Result register with saturation
  always_ff @(posedge clk) begin
    if (cmd.res_zero)       res <= '0;
    else if (cmd.res_mem16) res <= (mem_q > SUM_BITS'(WORD_MAX)) ? WORD_MAX : OUT_W'(mem_q);
    else if (cmd.div_wb)    res <= (quo > SUM_BITS'(BYTE_MAX)) ? BYTE_MAX : OUT_W'(quo);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst)            out_valid <= 1'b0;
    else if (cmd.emit)  out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) out_pixel <= res;
  end

  // Status
  assign stat.mode     = mode_r;
  assign stat.depth16  = cfg.depth_mode;
  assign stat.div_done = div_done;
  assign stat.clr_last = clr_addr == LAST_ADDR;
  assign stat.out_free = !out_valid || out_ready;

  // Checks
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("result not presented after emit");

  a_clr_exclusive: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_step |-> !(cmd.rd_en || cmd.acc_wr || cmd.div_wb))
    else $error("store access during clearing sweep");

  a_acc_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.acc_wr |-> (acc_sum >= mem_q))
    else $error("accumulated sum decreased");

  a_quo_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_wb |-> (quo <= mem_q))
    else $error("quotient exceeds the sum it came from");

endmodule

[hw/rtl/frame_accumulate_average.sv]
// Top level of the per-pixel frame accumulate/average block.
//
// Input channel in_ch carries one transaction per pixel: mode selects
// accumulate (add pixel_in to the sum at src_row/src_col inside the crop
// window), read out (emit one window pixel on out_ch) or clear (zero all
// sums). Output channel out_ch carries one transaction per readout.
// The user writes registers over the APB port only while the block is
// idle; the block itself does not enforce this.
//
// Each transaction is sequenced by the controller around the single store
// port with registered read: accumulate reads the sum and writes it back;
// readout reads the sum and, in byte mode, runs the bit-serial divider
// before the result goes out; clear sweeps the whole store to zero.
// After reset the store is swept to zero, one entry per cycle; in_ch.ready
// stays low meanwhile while register writes are taken. A result sits in the
// output register while the receiver stalls; the next transaction is
// accepted meanwhile and a further readout waits until that register frees
// up.
module frame_accumulate_average import faa_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int SUM_BITS   = SUM_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  faa_in_if.sink             in_ch,
  faa_out_if.source          out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  faa_cfg_t  cfg;
  faa_cmd_t  cmd;
  faa_stat_t stat;

  faa_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  faa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  faa_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .SUM_BITS   (SUM_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .stat      (stat),
    .in_mode   (in_ch.mode),
    .in_row    (in_ch.src_row),
    .in_col    (in_ch.src_col),
    .in_pix    (in_ch.pixel_in),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_pixel (out_ch.pixel_out)
  );

endmodule

[tb/tb_top.sv]
// Self-checking testbench for frame_accumulate_average: directed table, random phases, scoreboard.
`timescale 1ns / 100ps

module tb_top;
  import faa_pkg::*;

  localparam int STORE_W      = MAX_WIDTH_DEF;
  localparam int STORE_H      = MAX_HEIGHT_DEF;
  localparam int STORE_DEPTH  = STORE_W * STORE_H;
  localparam int CLEAR_CYCLES = STORE_DEPTH + 2;
  localparam int READ_CYCLES  = SUM_BITS_DEF + 5;
  localparam int NUM_REGS     = 5;
  localparam int LONG_HOLD    = 400;
  localparam int CYCLE_LIMIT  = 3_000_000;

  // Mode code the block ignores
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [COORD_W-1:0] src_row;
    logic [COORD_W-1:0] src_col;
    logic [PIX_W-1:0]   pixel_in;
  } pixel_req_t;

  typedef struct packed {
    logic               is_reg;
    logic [RIDX_W-1:0]  reg_idx;
    logic [PDATA_W-1:0] reg_val;
    pixel_req_t         req;
    logic               fixed_valid;
    logic [OUT_W-1:0]   fixed_pix;
  } stim_row_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  faa_in_if  in_ch ();
  faa_out_if out_ch ();

  frame_accumulate_average dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the block: register values and per-pixel sums
  logic [PDATA_W-1:0]      reg_shadow [NUM_REGS];
  logic [SUM_BITS_DEF-1:0] acc_sums [STORE_DEPTH];

  logic [OUT_W-1:0] due_pixels [$];
  stim_row_t        stim_rows [$];
  logic [MODE_W-1:0] last_mode = MODE_ACC;
  int               fail_count = 0;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  bit               stall_armed = 0;
  int               hold_left = 0;
  int               cycle_count = 0;
  logic [OUT_W-1:0] want_pix;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("frame_accumulate_average: mismatch");
      $finish;
    end
  end

  function automatic logic [PDATA_W-1:0] reg_mask(input logic [RIDX_W-1:0] idx);
    case (idx)
      REG_WINDOW_WIDTH, REG_WINDOW_HEIGHT: return {{(PDATA_W-WIN_W){1'b0}}, {WIN_W{1'b1}}};
      REG_ROW_OFFSET:  return {{(PDATA_W-COORD_W){1'b0}}, {COORD_W{1'b1}}};
      REG_FRAME_COUNT: return {{(PDATA_W-FC_W){1'b0}}, {FC_W{1'b1}}};
      REG_DEPTH_MODE:  return {{(PDATA_W-1){1'b0}}, 1'b1};
      default:         return '0;
    endcase
  endfunction

  // Window size as limited by the store
  function automatic int unsigned active_cols();
    int unsigned w;
    w = reg_shadow[REG_WINDOW_WIDTH];
    return (w > STORE_W) ? STORE_W : w;
  endfunction

  function automatic int unsigned active_rows();
    int unsigned h;
    h = reg_shadow[REG_WINDOW_HEIGHT];
    return (h > STORE_H) ? STORE_H : h;
  endfunction

  // Apply one transaction to the shadow store; returns 1 if it yields a pixel
  function automatic logic apply_pixel_op(input pixel_req_t req,
                                          output logic [OUT_W-1:0] pix_out);
    int unsigned w;
    int unsigned h;
    int unsigned wrow;
    int unsigned idx;
    logic [SUM_BITS_DEF:0]   grown;
    logic [SUM_BITS_DEF-1:0] divisor;
    logic [SUM_BITS_DEF-1:0] quot;
    w = active_cols();
    h = active_rows();
    pix_out = '0;
    case (req.mode)
      MODE_ACC: begin
        if (req.src_row < reg_shadow[REG_ROW_OFFSET]) return 1'b0;
        wrow = req.src_row - reg_shadow[REG_ROW_OFFSET];
        if (wrow >= h || req.src_col >= w) return 1'b0;
        idx = wrow * STORE_W + req.src_col;
        grown = {1'b0, acc_sums[idx]} + req.pixel_in;
        // saturate at the top of the sum range
        acc_sums[idx] = grown[SUM_BITS_DEF] ? '1 : grown[SUM_BITS_DEF-1:0];
        return 1'b0;
      end
      MODE_READ: begin
        if (req.src_row >= h || req.src_col >= w) return 1'b1;
        idx = req.src_row * STORE_W + req.src_col;
        if (reg_shadow[REG_DEPTH_MODE][0]) begin
          pix_out = (acc_sums[idx] > WORD_MAX) ? WORD_MAX : acc_sums[idx][OUT_W-1:0];
        end else begin
          // zero frame count divides by one; quotient replaces the sum
          divisor = (reg_shadow[REG_FRAME_COUNT] == 0) ? 1 : reg_shadow[REG_FRAME_COUNT];
          quot = acc_sums[idx] / divisor;
          acc_sums[idx] = quot;
          pix_out = (quot > BYTE_MAX) ? BYTE_MAX : quot[OUT_W-1:0];
        end
        return 1'b1;
      end
      MODE_CLEAR: begin
        for (int k = 0; k < STORE_DEPTH; k++) acc_sums[k] = '0;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Random transaction, mostly inside the current window
  function automatic pixel_req_t random_op(input bit dense);
    pixel_req_t  req;
    int unsigned pick;
    int unsigned w;
    int unsigned h;
    w = active_cols();
    h = active_rows();
    pick = $urandom_range(0, 99);
    if (dense) req.mode = (pick < 90) ? MODE_ACC : ((pick < 99) ? MODE_READ : MODE_UNUSED);
    else req.mode = (pick < 58) ? MODE_ACC : ((pick < 96) ? MODE_READ : MODE_UNUSED);
    req.pixel_in = (dense && $urandom_range(0, 19) != 0) ? 8'd255 : PIX_W'($urandom);
    if ($urandom_range(0, 99) < (dense ? 3 : 15)) begin
      req.src_row = COORD_W'($urandom);
      req.src_col = COORD_W'($urandom);
    end else begin
      req.src_col = (w == 0) ? '0 : COORD_W'($urandom_range(0, w - 1));
      req.src_row = (h == 0) ? '0 : COORD_W'($urandom_range(0, h - 1));
      if (req.mode == MODE_ACC) req.src_row = req.src_row + reg_shadow[REG_ROW_OFFSET][COORD_W-1:0];
    end
    return req;
  endfunction

  // One APB transfer, after which psel and penable return low
  task automatic apb_cycle(input logic wr, input logic [RIDX_W-1:0] idx,
                           input logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input logic [RIDX_W-1:0] idx);
    logic [PDATA_W-1:0] got;
    apb_cycle(1'b0, idx, '0, got);
    if (got !== reg_shadow[idx]) begin
      $display("%0t: register %0d expected %0h got %0h", $time, idx, reg_shadow[idx], got);
      fail_count++;
    end
  endtask

  task automatic set_reg(input logic [RIDX_W-1:0] idx, input logic [PDATA_W-1:0] val);
    logic [PDATA_W-1:0] unused_rd;
    apb_cycle(1'b1, idx, val, unused_rd);
    reg_shadow[idx] = val & reg_mask(idx);
    check_reg(idx);
  endtask

  // Offer one transaction, wait for the handshake, then predict its result
  task automatic offer_op(input pixel_req_t req, input logic fixed_valid,
                          input logic [OUT_W-1:0] fixed_pix);
    logic [OUT_W-1:0] predicted;
    logic             gives;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.mode     <= req.mode;
    in_ch.src_row  <= req.src_row;
    in_ch.src_col  <= req.src_col;
    in_ch.pixel_in <= req.pixel_in;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    gives = apply_pixel_op(req, predicted);
    if (gives) due_pixels.push_back(fixed_valid ? fixed_pix : predicted);
    last_mode = req.mode;
  endtask

  // Drain all results, then let the block finish any result-less work
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (due_pixels.size() != 0) @(posedge clk);
    repeat ((last_mode == MODE_CLEAR) ? CLEAR_CYCLES + 16 : READ_CYCLES + 16) @(posedge clk);
  endtask

  task automatic add_op(input logic [MODE_W-1:0] mode, input int row, input int col,
                        input int pix, input logic fixed_valid, input int fixed_pix);
    stim_row_t r;
    r = '0;
    r.req.mode     = mode;
    r.req.src_row  = COORD_W'(row);
    r.req.src_col  = COORD_W'(col);
    r.req.pixel_in = PIX_W'(pix);
    r.fixed_valid  = fixed_valid;
    r.fixed_pix    = OUT_W'(fixed_pix);
    stim_rows.push_back(r);
  endtask

  task automatic add_reg(input logic [RIDX_W-1:0] idx, input int val);
    stim_row_t r;
    r = '0;
    r.is_reg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = PDATA_W'(val);
    stim_rows.push_back(r);
  endtask

  // Random phase; optional mid-phase pause and clear
  task automatic run_random(input int count, input bit dense, input int pause_at,
                            input int clear_at);
    pixel_req_t req;
    for (int n = 0; n < count; n++) begin
      if (n == pause_at) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (due_pixels.size() != 0) @(posedge clk);
      end
      if (n == clear_at) begin
        req = random_op(1'b0);
        req.mode = MODE_CLEAR;
      end else begin
        req = random_op(dense);
      end
      offer_op(req, 1'b0, '0);
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (due_pixels.size() == 0) begin
        $display("%0t: pixel_out expected none got %0d", $time, out_ch.pixel_out);
        fail_count++;
      end else begin
        want_pix = due_pixels.pop_front();
        if (out_ch.pixel_out !== want_pix) begin
          $display("%0t: pixel_out expected %0d got %0d", $time, want_pix, out_ch.pixel_out);
          fail_count++;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off when armed
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && stall_armed && out_ch.valid && !rst) begin
        hold_left = LONG_HOLD;
        stall_armed = 0;
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Main sequence
  initial begin
    rst            <= 1'b1;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.mode     <= '0;
    in_ch.src_row  <= '0;
    in_ch.src_col  <= '0;
    in_ch.pixel_in <= '0;
    reg_shadow[REG_WINDOW_WIDTH]  = PDATA_W'(RST_WINDOW_WIDTH);
    reg_shadow[REG_WINDOW_HEIGHT] = PDATA_W'(RST_WINDOW_HEIGHT);
    reg_shadow[REG_ROW_OFFSET]    = PDATA_W'(RST_ROW_OFFSET);
    reg_shadow[REG_FRAME_COUNT]   = PDATA_W'(RST_FRAME_COUNT);
    reg_shadow[REG_DEPTH_MODE]    = '0;
    for (int k = 0; k < STORE_DEPTH; k++) acc_sums[k] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // register values after reset
    for (int r = 0; r < NUM_REGS; r++) check_reg(RIDX_W'(r));

    // Directed part
    send_idle_pct = 14;
    recv_idle_pct = 78;
    add_op(MODE_ACC, 0, 0, 255, 1'b0, 0);
    add_op(MODE_ACC, 0, 0, 255, 1'b0, 0);
    add_op(MODE_READ, 0, 0, 0, 1'b1, BYTE_MAX);     // 510 clipped to a byte
    add_reg(REG_DEPTH_MODE, 1);
    add_op(MODE_READ, 0, 0, 0, 1'b1, 510);
    add_op(MODE_READ, 4095, 4095, 0, 1'b1, 0);      // readout outside the window
    add_op(MODE_ACC, 4095, 4095, 8'hA5, 1'b0, 0);   // outside, ignored
    add_op(MODE_ACC, 255, 255, 1, 1'b0, 0);         // far corner
    add_op(MODE_READ, 255, 255, 0, 1'b1, 1);
    add_op(MODE_READ, 256, 0, 0, 1'b1, 0);
    add_op(MODE_UNUSED, 0, 0, 255, 1'b0, 0);
    add_op(MODE_READ, 0, 0, 0, 1'b1, 510);
    add_op(MODE_CLEAR, 0, 0, 0, 1'b0, 0);
    add_op(MODE_READ, 0, 0, 0, 1'b1, 0);
    add_reg(REG_WINDOW_WIDTH, 0);                   // zero-size window
    add_op(MODE_ACC, 0, 0, 200, 1'b0, 0);
    add_op(MODE_READ, 0, 0, 0, 1'b1, 0);
    add_reg(REG_WINDOW_WIDTH, 511);                 // wider than the store
    add_reg(REG_WINDOW_HEIGHT, 1);
    add_reg(REG_ROW_OFFSET, 4095);
    add_reg(REG_FRAME_COUNT, 0);
    add_reg(REG_DEPTH_MODE, 0);
    add_op(MODE_ACC, 4094, 10, 77, 1'b0, 0);        // row below the offset
    add_op(MODE_ACC, 4095, 10, 100, 1'b0, 0);
    add_op(MODE_ACC, 4095, 10, 100, 1'b0, 0);
    add_op(MODE_READ, 0, 10, 0, 1'b1, 200);         // zero frame count divides by one
    add_op(MODE_READ, 1, 10, 0, 1'b1, 0);
    add_op(MODE_ACC, 4095, 255, 255, 1'b0, 0);
    add_op(MODE_ACC, 4095, 300, 255, 1'b0, 0);      // past the store width
    add_reg(REG_FRAME_COUNT, 65535);
    add_op(MODE_READ, 0, 255, 0, 1'b1, 0);
    add_reg(REG_FRAME_COUNT, 3);
    add_op(MODE_READ, 0, 10, 0, 1'b0, 0);
    add_op(MODE_READ, 0, 10, 0, 1'b0, 0);
    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_reg) begin
        quiesce();
        set_reg(stim_rows[i].reg_idx, stim_rows[i].reg_val);
      end else begin
        offer_op(stim_rows[i].req, stim_rows[i].fixed_valid, stim_rows[i].fixed_pix);
      end
    end

    // Phase 1: small byte-mode window, slow receiver
    quiesce();
    set_reg(REG_WINDOW_WIDTH, 13);
    set_reg(REG_WINDOW_HEIGHT, 9);
    set_reg(REG_ROW_OFFSET, $urandom_range(0, 4095 - 9));
    set_reg(REG_FRAME_COUNT, $urandom_range(2, 5));
    set_reg(REG_DEPTH_MODE, 0);
    send_idle_pct = 14;
    recv_idle_pct = 78;
    run_random(30, 1'b0, -1, 0);

    // Phase 2: single pixel, 16-bit sums driven into saturation
    quiesce();
    set_reg(REG_WINDOW_WIDTH, 1);
    set_reg(REG_WINDOW_HEIGHT, 1);
    set_reg(REG_ROW_OFFSET, 4095);
    set_reg(REG_FRAME_COUNT, $urandom_range(1, 65535));
    set_reg(REG_DEPTH_MODE, 1);
    send_idle_pct = 78;
    recv_idle_pct = 14;
    run_random(360, 1'b1, 180, -1);

    // Phase 3: random window, no idling, one long receiver hold-off
    quiesce();
    set_reg(REG_WINDOW_WIDTH, $urandom_range(1, 20));
    set_reg(REG_WINDOW_HEIGHT, $urandom_range(1, 20));
    set_reg(REG_ROW_OFFSET, $urandom_range(0, 4095));
    set_reg(REG_FRAME_COUNT, $urandom_range(1, 3));
    set_reg(REG_DEPTH_MODE, $urandom_range(0, 1));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_armed = 1;
    run_random(30, 1'b0, -1, 15);

    quiesce();
    if (fail_count == 0) begin
      $display("frame_accumulate_average: match");
    end else begin
      $display("frame_accumulate_average: mismatch");
    end
    $finish;
  end

endmodule
